[sv/dfpa_pkg.sv]
// Shared types and constants for the delimited field parser with averaging.
// No dependencies; the files that use it refer to this package by scoped names.
`default_nettype none

package dfpa_pkg;

    // Operation codes on the input channel
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_EOF   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Character codes
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int VAL_W = 16;
    localparam int FN_W  = 3;
    localparam logic [FN_W-1:0] FIELDS_PER_FRAME = 3'd4;
    localparam logic [FN_W-1:0] FIELD_THIRD      = 3'd2;
    localparam logic [FN_W-1:0] FIELD_FOURTH     = 3'd3;

    // Delimiter that closes a given field
    function automatic logic [7:0] delim_of(input logic [1:0] field);
        logic [7:0] ch;
        case (field)
            2'd0:    ch = CH_A;
            2'd1:    ch = CH_X;
            2'd2:    ch = CH_D;
            default: ch = CH_B;
        endcase
        return ch;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic take_byte;
        logic clear_hold;
        logic push;
        logic scan;
        logic div_load;
        logic div_step;
        logic finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

[sv/dfpa_ifs.sv]
// Valid/ready channel interfaces for the parser: input items and results.
// Depends on nothing; payload widths are fixed by the item format.
`default_nettype none

interface dfpa_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface dfpa_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] x_average;
    logic [15:0] d_average;
    logic        x_updated;
    logic        d_updated;
    logic [2:0]  fields_closed;

    modport source (output valid, output x_average, output d_average, output x_updated,
                    output d_updated, output fields_closed, input ready);
    modport sink   (input valid, input x_average, input d_average, input x_updated,
                    input d_updated, input fields_closed, output ready);
endinterface

`default_nettype wire

[sv/dfpa_ctrl.sv]
// Controller state machine: sequences byte parsing, ring push, scan, divide
// and result hand-off. Depends on dfpa_pkg for the command/status structs.
`default_nettype none

module dfpa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [1:0]    in_op,
    output logic               in_ready,
    input  wire dfpa_pkg::sts_t sts,
    output dfpa_pkg::cmd_t     cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        dfpa_pkg::OP_BYTE:  cmd.take_byte  = 1'b1;
                        dfpa_pkg::OP_CLEAR: cmd.clear_hold = 1'b1;
                        dfpa_pkg::OP_EOF:
                        begin
                            cmd.push   = 1'b1;
                            state_next = S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[sv/dfpa_datapath.sv]
// Datapath: frame parser registers, two averaging rings, nonzero sum/count
// scan, two bit-serial dividers and the result register. Depends on dfpa_pkg.
`default_nettype none

module dfpa_datapath #(
    parameter int RING_DEPTH  = 5,
    parameter int FIELD_CHARS = 9
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dfpa_pkg::cmd_t cmd,
    input  wire logic [7:0]     rx_byte,
    output dfpa_pkg::sts_t      sts,
    input  wire logic           out_ready,
    output logic                out_valid,
    output logic [15:0]         x_average,
    output logic [15:0]         d_average,
    output logic                x_updated,
    output logic                d_updated,
    output logic [2:0]          fields_closed
);

    localparam int VW    = dfpa_pkg::VAL_W;
    localparam int POS_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = VW + CNT_W;
    localparam int DC_W  = $clog2(SUM_W);
    localparam int CC_W  = $clog2(FIELD_CHARS + 1);

    // Frame parser state
    logic [dfpa_pkg::FN_W-1:0] field_reg,  field_next;
    logic                      stop_reg,   stop_next;
    logic [CC_W-1:0]           cc_reg,     cc_next;
    logic [VW-1:0]             third_reg,  third_next;
    logic [VW-1:0]             fourth_reg, fourth_next;

    // Rings (both channels share position and fill; they are pushed together)
    logic [VW-1:0]    ring_reg [2][RING_DEPTH];
    logic [POS_W-1:0] pos_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [VW-1:0]    hold_reg [2];

    // Scan and divide working registers
    logic [POS_W-1:0] idx_reg;
    logic [SUM_W-1:0] sum_reg [2];
    logic [CNT_W-1:0] cnt_reg [2];
    logic [SUM_W-1:0] quo_reg [2];
    logic [CNT_W-1:0] rem_reg [2];
    logic [DC_W-1:0]  dcnt_reg;

    logic [SUM_W-1:0] quo_next [2];
    logic [CNT_W-1:0] rem_next [2];
    logic [CNT_W:0]   trial    [2];
    logic [VW-1:0]    avg      [2];
    logic             upd      [2];

    // Result register
    logic             ov_reg;
    logic [VW-1:0]    oavg_reg [2];
    logic             oupd_reg [2];
    logic [2:0]       ofc_reg;

    logic [3:0]       digit;
    logic             is_digit;

    // Byte parsing; an ASCII digit carries its value in the low nibble
    assign digit    = rx_byte[3:0];
    assign is_digit = (rx_byte >= dfpa_pkg::CH_ZERO) && (rx_byte <= dfpa_pkg::CH_NINE);

    always_comb
    begin
        field_next  = field_reg;
        stop_next   = stop_reg;
        cc_next     = cc_reg;
        third_next  = third_reg;
        fourth_next = fourth_reg;
        if (cmd.take_byte && !stop_reg && (field_reg < dfpa_pkg::FIELDS_PER_FRAME))
        begin
            if (rx_byte == dfpa_pkg::delim_of(field_reg[1:0]))
            begin
                field_next = field_reg + 1'b1;
                cc_next    = '0;
            end
            else if (cc_reg >= CC_W'(FIELD_CHARS))
            begin
                stop_next = 1'b1;
            end
            else if (rx_byte != dfpa_pkg::CH_DOT)
            begin
                cc_next = cc_reg + 1'b1;
                if (is_digit && (field_reg == dfpa_pkg::FIELD_THIRD))
                begin
                    // v*10 + d, wrapping at 16 bits
                    third_next = (third_reg << 3) + (third_reg << 1) + VW'(digit);
                end
                if (is_digit && (field_reg == dfpa_pkg::FIELD_FOURTH))
                begin
                    fourth_next = (fourth_reg << 3) + (fourth_reg << 1) + VW'(digit);
                end
            end
        end
    end

    // One restoring-division step per channel
    always_comb
    begin
        for (int ch = 0; ch < 2; ch++)
        begin
            trial[ch] = {rem_reg[ch], quo_reg[ch][SUM_W-1]};
            if (trial[ch] >= {1'b0, cnt_reg[ch]})
            begin
                rem_next[ch] = CNT_W'(trial[ch] - {1'b0, cnt_reg[ch]});
                quo_next[ch] = {quo_reg[ch][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[ch] = trial[ch][CNT_W-1:0];
                quo_next[ch] = {quo_reg[ch][SUM_W-2:0], 1'b0};
            end
            upd[ch] = (cnt_reg[ch] != '0);
            avg[ch] = upd[ch] ? quo_reg[ch][VW-1:0] : hold_reg[ch];
        end
    end

    assign sts.scan_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == fill_reg);
    assign sts.div_last  = (dcnt_reg == DC_W'(SUM_W - 1));
    assign sts.out_free  = !ov_reg || out_ready;

    // Model state, rings and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_reg  <= '0;
            stop_reg   <= 1'b0;
            cc_reg     <= '0;
            third_reg  <= '0;
            fourth_reg <= '0;
            pos_reg    <= '0;
            fill_reg   <= '0;
            ov_reg     <= 1'b0;
            for (int ch = 0; ch < 2; ch++)
            begin
                hold_reg[ch] <= '0;
                for (int i = 0; i < RING_DEPTH; i++)
                begin
                    ring_reg[ch][i] <= '0;
                end
            end
        end
        else
        begin
            if (cmd.finish)
            begin
                // frame closed: start the next one clean
                field_reg  <= '0;
                stop_reg   <= 1'b0;
                cc_reg     <= '0;
                third_reg  <= '0;
                fourth_reg <= '0;
            end
            else
            begin
                field_reg  <= field_next;
                stop_reg   <= stop_next;
                cc_reg     <= cc_next;
                third_reg  <= third_next;
                fourth_reg <= fourth_next;
            end

            if (cmd.push)
            begin
                ring_reg[0][pos_reg] <= third_reg;
                ring_reg[1][pos_reg] <= fourth_reg;
                pos_reg <= (pos_reg == POS_W'(RING_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
                if (fill_reg != CNT_W'(RING_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end

            for (int ch = 0; ch < 2; ch++)
            begin
                if (cmd.clear_hold)
                begin
                    hold_reg[ch] <= '0;
                end
                else if (cmd.finish && upd[ch])
                begin
                    hold_reg[ch] <= quo_reg[ch][VW-1:0];
                end
            end

            if (cmd.finish)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Scan, divide and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            idx_reg <= '0;
        end
        else if (cmd.scan)
        begin
            idx_reg <= idx_reg + 1'b1;
        end

        if (cmd.div_load)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
        end

        for (int ch = 0; ch < 2; ch++)
        begin
            if (cmd.push)
            begin
                sum_reg[ch] <= '0;
                cnt_reg[ch] <= '0;
            end
            else if (cmd.scan && (ring_reg[ch][idx_reg] != '0))
            begin
                sum_reg[ch] <= sum_reg[ch] + SUM_W'(ring_reg[ch][idx_reg]);
                cnt_reg[ch] <= cnt_reg[ch] + 1'b1;
            end

            if (cmd.div_load)
            begin
                quo_reg[ch] <= sum_reg[ch];
                rem_reg[ch] <= '0;
            end
            else if (cmd.div_step)
            begin
                quo_reg[ch] <= quo_next[ch];
                rem_reg[ch] <= rem_next[ch];
            end

            if (cmd.finish)
            begin
                oavg_reg[ch] <= avg[ch];
                oupd_reg[ch] <= upd[ch];
            end
        end

        if (cmd.finish)
        begin
            ofc_reg <= field_reg;
        end
    end

    assign out_valid     = ov_reg;
    assign x_average     = oavg_reg[0];
    assign d_average     = oavg_reg[1];
    assign x_updated     = oupd_reg[0];
    assign d_updated     = oupd_reg[1];
    assign fields_closed = ofc_reg;

endmodule

`default_nettype wire

[sv/delimited_field_parser_with_average_core.sv]
// Top level of the delimited field parser with per-channel averaging.
// Depends on dfpa_pkg, dfpa_ifs, dfpa_ctrl and dfpa_datapath.
//
//   channel   direction  payload                                          transfer
//   in_ch     in         op[1:0], rx_byte[7:0]                            valid & ready
//   out_ch    out        x_average, d_average, x_updated, d_updated,      valid & ready
//                        fields_closed[2:0]
//
// Frame bytes and clear ops leave the controller idle; input stays ready back to back.
// End of frame pushes both rings, then scans the filled ring entries, loads the
// dividers and runs a one-bit-per-cycle divide of the nonzero sum.
// The result sits in an output register; a stalled sink only holds the next frame
// end in its final cycle. Reset is asynchronous, active low, and clears rings,
// averages and the frame in progress; no clearing pass is needed.
`default_nettype none

module delimited_field_parser_with_average_core #(
    parameter int RING_DEPTH  = 5,
    parameter int FIELD_CHARS = 9
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dfpa_in_if.sink     in_ch,
    dfpa_out_if.source  out_ch
);

    dfpa_pkg::cmd_t cmd;
    dfpa_pkg::sts_t sts;

    dfpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (in_ch.op),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dfpa_datapath #(
        .RING_DEPTH  (RING_DEPTH),
        .FIELD_CHARS (FIELD_CHARS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rx_byte       (in_ch.rx_byte),
        .sts           (sts),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .x_average     (out_ch.x_average),
        .d_average     (out_ch.d_average),
        .x_updated     (out_ch.x_updated),
        .d_updated     (out_ch.d_updated),
        .fields_closed (out_ch.fields_closed)
    );

    // A frame never closes more fields than it has
    a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.fields_closed <= dfpa_pkg::FIELDS_PER_FRAME))
        else $error("fields_closed out of range");

    // A mean over nonzero entries is itself nonzero
    a_x_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.x_updated) |-> (out_ch.x_average != '0))
        else $error("x average zero with update flag");

    a_d_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.d_updated) |-> (out_ch.d_average != '0))
        else $error("d average zero with update flag");

    // Frame end starts a busy sequence; input is held off the next cycle
    a_eof_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.op == dfpa_pkg::OP_EOF)) |=> !in_ch.ready)
        else $error("input ready during frame-end processing");

endmodule

`default_nettype wire

[sim/dfpa_average_monitor.sv]
`timescale 1ns / 1ps
// Result monitor for the delimited field parser: follows input transfers, predicts
// each frame-end report and compares it with every result transfer.
// Depends on dfpa_pkg and the channel interfaces in dfpa_ifs.

module dfpa_average_monitor #(
    parameter int RING_DEPTH  = 5,
    parameter int FIELD_CHARS = 9
) (
    input  logic clk,
    input  logic rst_n,
    dfpa_in_if   in_ch,
    dfpa_out_if  out_ch,
    output int   mismatches,
    output int   reports_owed
);

    typedef struct packed {
        logic [15:0] x_average;
        logic [15:0] d_average;
        logic        x_updated;
        logic        d_updated;
        logic [2:0]  fields_closed;
    } frame_report_t;

    // Field closers, indexed by field number
    localparam logic [3:0][7:0] CLOSERS = {dfpa_pkg::CH_B, dfpa_pkg::CH_D,
                                           dfpa_pkg::CH_X, dfpa_pkg::CH_A};

    // Frame in progress
    logic [2:0]    field_idx;
    logic          halted;
    int            field_len;
    logic [15:0]   x_value;
    logic [15:0]   d_value;

    // Filter state: channel 0 is x, channel 1 is d
    logic [15:0]   ring [2][RING_DEPTH];
    int            ring_wr [2];
    int            ring_cnt [2];
    logic [15:0]   avg_hold [2];

    frame_report_t owed_reports [$];

    initial
    begin
        mismatches   = 0;
        reports_owed = 0;
    end

    task automatic clear_frame();
        field_idx = '0;
        halted    = 1'b0;
        field_len = 0;
        x_value   = '0;
        d_value   = '0;
    endtask

    // One frame byte through the field parser
    task automatic take_byte(input logic [7:0] b);
        if (!halted && field_idx < dfpa_pkg::FIELDS_PER_FRAME)
        begin
            if (b == CLOSERS[field_idx[1:0]])
            begin
                field_idx = field_idx + 3'd1;
                field_len = 0;
            end
            else if (field_len >= FIELD_CHARS)
                halted = 1'b1;
            else if (b != dfpa_pkg::CH_DOT)
            begin
                field_len++;
                if (b >= dfpa_pkg::CH_ZERO && b <= dfpa_pkg::CH_NINE)
                begin
                    if (field_idx == dfpa_pkg::FIELD_THIRD)
                        x_value = x_value * 16'd10 + {8'h00, b - dfpa_pkg::CH_ZERO};
                    else if (field_idx == dfpa_pkg::FIELD_FOURTH)
                        d_value = d_value * 16'd10 + {8'h00, b - dfpa_pkg::CH_ZERO};
                end
            end
        end
    endtask

    // Enter a value into a ring and refresh the hold if any filled entry is nonzero
    task automatic push_and_average(input int ch, input logic [15:0] v, output logic any_nz);
        int unsigned total;
        int unsigned nz;
        total = 0;
        nz    = 0;
        ring[ch][ring_wr[ch]] = v;
        ring_wr[ch] = (ring_wr[ch] + 1) % RING_DEPTH;
        if (ring_cnt[ch] < RING_DEPTH)
            ring_cnt[ch]++;
        for (int i = 0; i < ring_cnt[ch]; i++)
        begin
            if (ring[ch][i] != 16'd0)
            begin
                total += ring[ch][i];
                nz++;
            end
        end
        any_nz = (nz != 0);
        if (any_nz)
            avg_hold[ch] = total / nz;
    endtask

    task automatic close_frame();
        frame_report_t rep;
        logic          xu;
        logic          du;
        push_and_average(0, x_value, xu);
        push_and_average(1, d_value, du);
        rep.x_average     = avg_hold[0];
        rep.d_average     = avg_hold[1];
        rep.x_updated     = xu;
        rep.d_updated     = du;
        rep.fields_closed = field_idx;
        owed_reports.push_back(rep);
        clear_frame();
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_report();
        frame_report_t want;
        if (owed_reports.size() == 0)
        begin
            $error("result transfer with no frame end pending");
            mismatches++;
        end
        else
        begin
            want = owed_reports.pop_front();
            check_field("x_average", want.x_average, out_ch.x_average);
            check_field("d_average", want.d_average, out_ch.d_average);
            check_field("x_updated", want.x_updated, out_ch.x_updated);
            check_field("d_updated", want.d_updated, out_ch.d_updated);
            check_field("fields_closed", want.fields_closed, out_ch.fields_closed);
        end
    endtask

    // Follow both channels; inputs first, then the result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            for (int c = 0; c < 2; c++)
            begin
                for (int i = 0; i < RING_DEPTH; i++)
                    ring[c][i] = '0;
                ring_wr[c]  = 0;
                ring_cnt[c] = 0;
                avg_hold[c] = '0;
            end
            owed_reports.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                case (in_ch.op)
                    dfpa_pkg::OP_BYTE:  take_byte(in_ch.rx_byte);
                    dfpa_pkg::OP_EOF:   close_frame();
                    dfpa_pkg::OP_CLEAR:
                    begin
                        avg_hold[0] = '0;
                        avg_hold[1] = '0;
                    end
                    default:  ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
                check_report();
        end
        reports_owed = owed_reports.size();
    end

endmodule

[sim/delimited_field_parser_with_average_core_test.sv]
`timescale 1ns / 1ps
// Testbench top for the delimited field parser: clock, reset, frame stimulus,
// result-side stalls and the verdict. Depends on dfpa_pkg, dfpa_ifs, the core
// and dfpa_average_monitor.

module delimited_field_parser_with_average_core_test;

    localparam logic [1:0]      OP_UNUSED    = 2'd3;
    localparam logic [3:0][7:0] CLOSERS      = {dfpa_pkg::CH_B, dfpa_pkg::CH_D,
                                                dfpa_pkg::CH_X, dfpa_pkg::CH_A};
    localparam int              RANDOM_ITEMS = 1700;
    localparam int              TAIL_START   = 1450;
    localparam int              HOLD_AT      = 500;
    localparam int              PAUSE_AT     = 1000;
    localparam int              HOLD_CYCLES  = 300;
    localparam int              DRAIN_CYCLES = 40;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   reports_owed;
    int   items_sent  = 0;
    bit   quiet_tail  = 1'b0;
    bit   sender_gaps = 1'b0;
    bit   hold_req    = 1'b0;

    dfpa_in_if  in_ch ();
    dfpa_out_if out_ch ();

    delimited_field_parser_with_average_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    dfpa_average_monitor i_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .mismatches   (mismatches),
        .reports_owed (reports_owed)
    );

    always #2 clk = ~clk;

    // Run limit
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // One input transfer, optionally preceded by an idle burst
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        if (sender_gaps && !quiet_tail && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.op      <= op;
        in_ch.rx_byte <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Field character: digits dominate the numeric fields
    function automatic logic [7:0] field_char(input bit numeric);
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (numeric && r < 75)
            c = dfpa_pkg::CH_ZERO + $urandom_range(0, 9);
        else if (numeric && r < 85)
            c = dfpa_pkg::CH_DOT;
        else if (!numeric && r < 15)
            c = dfpa_pkg::CH_ZERO + $urandom_range(0, 9);
        else if (!numeric && r < 25)
            c = dfpa_pkg::CH_DOT;
        else if (!numeric && r < 45)
            c = CLOSERS[$urandom_range(0, 3)];
        else
            c = $urandom_range(0, 255);
        return c;
    endfunction

    // Mostly short fields, some near full, some overflowing
    function automatic int field_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return $urandom_range(10, 13);
        else if (r < 30)
            return $urandom_range(7, 9);
        return $urandom_range(0, 5);
    endfunction

    task automatic send_field_body(input int field, input int len);
        for (int i = 0; i < len; i++)
        begin
            // occasional clear or unused op inside a frame
            if ($urandom_range(0, 49) == 0)
                send_item(($urandom_range(0, 1) != 0) ? dfpa_pkg::OP_CLEAR : OP_UNUSED,
                          $urandom_range(0, 255));
            send_item(dfpa_pkg::OP_BYTE, field_char(field >= 2));
        end
    endtask

    task automatic send_frame();
        int         kind;
        int         cut;
        int         r;
        logic [1:0] op;
        kind = $urandom_range(0, 99);
        if (kind < 4)
        begin
            // run of empty frames flushes nonzero entries out of the rings
            repeat (5 + $urandom_range(0, 2))
            begin
                if ($urandom_range(0, 1) != 0)
                    for (int f = 0; f < 4; f++)
                        send_item(dfpa_pkg::OP_BYTE, CLOSERS[f]);
                send_item(dfpa_pkg::OP_EOF, $urandom_range(0, 255));
            end
        end
        else if (kind < 90)
        begin
            // well-formed frame, or one cut short inside field 'cut'
            cut = (kind < 75) ? 4 : $urandom_range(0, 3);
            for (int f = 0; f < 4 && f <= cut; f++)
            begin
                send_field_body(f, field_length());
                if (f < cut)
                    send_item(dfpa_pkg::OP_BYTE, CLOSERS[f]);
            end
            if (cut == 4 && $urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    send_item(dfpa_pkg::OP_BYTE, $urandom_range(0, 255));
            send_item(dfpa_pkg::OP_EOF, $urandom_range(0, 255));
        end
        else
        begin
            // noise: any op, any byte
            repeat ($urandom_range(1, 8))
            begin
                r  = $urandom_range(0, 9);
                op = (r < 6) ? dfpa_pkg::OP_BYTE :
                     (r < 8) ? dfpa_pkg::OP_EOF :
                     (r < 9) ? dfpa_pkg::OP_CLEAR : OP_UNUSED;
                send_item(op, $urandom_range(0, 255));
            end
        end
    endtask

    // Result side: random stall bursts, free-running stretches, one long hold-off
    initial
    begin : result_sink
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 2) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    repeat (200) @(posedge clk);
                else
                    repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        bit hold_sent;
        bit pause_done;
        hold_sent  = 1'b0;
        pause_done = 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.op      <= dfpa_pkg::OP_BYTE;
        in_ch.rx_byte <= 8'h00;
        rst_n         <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty frame right after reset, clear, unused op
        send_item(dfpa_pkg::OP_EOF, 8'hFF);
        send_item(dfpa_pkg::OP_CLEAR, 8'h00);
        send_item(OP_UNUSED, 8'hFF);
        // full frame: NUL and a foreign delimiter as plain characters, dots dropped
        send_item(dfpa_pkg::OP_BYTE, 8'h00);
        send_item(dfpa_pkg::OP_BYTE, dfpa_pkg::CH_A);
        send_item(dfpa_pkg::OP_BYTE, dfpa_pkg::CH_D);
        send_item(dfpa_pkg::OP_BYTE, dfpa_pkg::CH_X);
        send_item(dfpa_pkg::OP_BYTE, dfpa_pkg::CH_NINE);
        send_item(dfpa_pkg::OP_BYTE, dfpa_pkg::CH_DOT);
        send_item(dfpa_pkg::OP_BYTE, dfpa_pkg::CH_NINE);
        send_item(dfpa_pkg::OP_BYTE, dfpa_pkg::CH_D);
        send_item(dfpa_pkg::OP_BYTE, dfpa_pkg::CH_ZERO);
        send_item(dfpa_pkg::OP_BYTE, dfpa_pkg::CH_B);
        // bytes after the fourth delimiter are ignored
        send_item(dfpa_pkg::OP_BYTE, dfpa_pkg::CH_X);
        send_item(dfpa_pkg::OP_EOF, 8'h00);
        // field full: a dot as the tenth character stops the frame
        repeat (9) send_item(dfpa_pkg::OP_BYTE, dfpa_pkg::CH_NINE);
        send_item(dfpa_pkg::OP_BYTE, dfpa_pkg::CH_DOT);
        send_item(dfpa_pkg::OP_BYTE, dfpa_pkg::CH_A);
        send_item(dfpa_pkg::OP_EOF, 8'h00);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            quiet_tail  = (items_sent >= TAIL_START);
            sender_gaps = ($urandom_range(0, 3) != 0);
            if (!hold_sent && items_sent >= HOLD_AT)
            begin
                hold_req  = 1'b1;
                hold_sent = 1'b1;
            end
            if (!pause_done && items_sent >= PAUSE_AT)
            begin
                // sender waits until every report has come back
                in_ch.valid <= 1'b0;
                @(posedge clk);
                wait (reports_owed == 0);
                @(posedge clk);
                pause_done = 1'b1;
            end
            send_frame();
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (reports_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && reports_owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
sv/dfpa_pkg.sv
sv/dfpa_ifs.sv
sv/dfpa_ctrl.sv
sv/dfpa_datapath.sv
sv/delimited_field_parser_with_average_core.sv
sim/dfpa_average_monitor.sv
sim/delimited_field_parser_with_average_core_test.sv
